/* hw/rtl/csbc_pkg.sv */
`default_nettype none
package csbc_pkg;

   localparam int unsigned TICK_W      = 16;
   localparam int unsigned HOURS_W     = 5;
   localparam int unsigned MINUTES_W   = 6;
   localparam int unsigned SECONDS_W   = 6;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = TICK_W;

   localparam logic [HOURS_W:0]     HOURS_PER_DAY    = (HOURS_W + 1)'(24);
   localparam logic [MINUTES_W:0]   MINUTES_PER_HOUR = (MINUTES_W + 1)'(60);
   localparam logic [TICK_W-1:0]    TICK_MAX         = '1;
   localparam logic [TICK_W-1:0]    HOLD_TICKS_RESET = TICK_W'(31250);
   localparam logic [TICK_W-1:0]    QUIT_TICKS_RESET = TICK_W'(62500);

   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIT_TICKS = CSR_INDEX_W'(1);

   typedef struct packed {
      logic                 button_one_down;
      logic                 button_two_down;
      logic                 time_valid;
      logic [HOURS_W-1:0]   hours_in;
      logic [MINUTES_W-1:0] minutes_in;
      logic [SECONDS_W-1:0] seconds_in;
   } req_type;

   typedef struct packed {
      logic                 set_mode;
      logic                 write_strobe;
      logic                 show_strobe;
      logic [HOURS_W-1:0]   hours_out;
      logic [MINUTES_W-1:0] minutes_out;
      logic [SECONDS_W-1:0] seconds_out;
   } rsp_type;

   typedef struct packed {
      logic                 setting_mode;
      logic                 timer_running;
      logic [TICK_W-1:0]    tick_count;
      logic [1:0]           previous_buttons;
      logic [1:0]           armed_flags;
      logic [1:0]           pending_flags;
      logic [HOURS_W-1:0]   hours;
      logic [MINUTES_W-1:0] minutes;
      logic [SECONDS_W-1:0] seconds;
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0] hold_ticks;
      logic [TICK_W-1:0] quit_ticks;
   } cfg_type;

endpackage
`default_nettype wire

/* hw/rtl/csbc_step.sv */
`default_nettype none
module csbc_step (
   input  wire csbc_pkg::state_type state,
   input  wire csbc_pkg::cfg_type   cfg,
   input  wire csbc_pkg::req_type   item,
   output csbc_pkg::state_type      state_next,
   output csbc_pkg::rsp_type        result
);

   logic                                b1;
   logic                                b2;
   logic                                both;
   logic [1:0]                          levels;
   logic                                run;
   logic [csbc_pkg::TICK_W-1:0]         cnt;
   logic [csbc_pkg::TICK_W-1:0]         target;
   logic                                mode;
   logic [1:0]                          armed;
   logic [1:0]                          pending;
   logic [csbc_pkg::HOURS_W-1:0]        hours;
   logic [csbc_pkg::MINUTES_W-1:0]      minutes;
   logic [csbc_pkg::SECONDS_W-1:0]      seconds;
   logic [csbc_pkg::HOURS_W:0]          hours_inc;
   logic [csbc_pkg::MINUTES_W:0]        minutes_inc;
   logic                                write;
   logic                                show;

   always_comb begin
      b1      = item.button_one_down;
      b2      = item.button_two_down;
      both    = b1 & b2;
      levels  = {b2, b1};
      mode    = state.setting_mode;
      armed   = state.armed_flags;
      pending = state.pending_flags;
      write   = 1'b0;
      show    = 1'b0;
      run     = state.timer_running;
      cnt     = state.tick_count;
      target  = state.setting_mode ? cfg.quit_ticks : cfg.hold_ticks;

      if (levels != state.previous_buttons) begin
         run = 1'b0;
         cnt = '0;
      end

      // tick and expiry
      if (run) begin
         if (cnt != csbc_pkg::TICK_MAX) begin
            cnt = cnt + csbc_pkg::TICK_W'(1);
         end
         if (cnt >= target) begin
            run = 1'b0;
            cnt = '0;
            if (!mode && both) begin
               mode = 1'b1;
            end else if (mode) begin
               mode = 1'b0;
            end
         end
      end

      if (item.time_valid) begin
         hours   = item.hours_in;
         minutes = item.minutes_in;
         seconds = item.seconds_in;
         show    = 1'b1;
      end else begin
         hours   = state.hours;
         minutes = state.minutes;
         seconds = state.seconds;
      end

      hours_inc = {1'b0, hours} + (csbc_pkg::HOURS_W + 1)'(1);
      if (hours_inc >= csbc_pkg::HOURS_PER_DAY) begin
         hours_inc = hours_inc - csbc_pkg::HOURS_PER_DAY;
      end
      minutes_inc = {1'b0, minutes} + (csbc_pkg::MINUTES_W + 1)'(1);
      if (minutes_inc >= csbc_pkg::MINUTES_PER_HOUR) begin
         minutes_inc = minutes_inc - csbc_pkg::MINUTES_PER_HOUR;
      end

      if (pending[0] && b1 && armed[0]) begin
         pending[0] = 1'b0;
         armed[0]   = 1'b0;
         seconds    = '0;
         hours      = hours_inc[csbc_pkg::HOURS_W-1:0];
         write      = 1'b1;
      end
      if (pending[1] && b2 && armed[1]) begin
         pending[1] = 1'b0;
         armed[1]   = 1'b0;
         seconds    = '0;
         minutes    = minutes_inc[csbc_pkg::MINUTES_W-1:0];
         write      = 1'b1;
      end
      if (write) begin
         show = 1'b1;
      end

      if (!mode) begin
         armed = 2'b00;
         if (both) begin
            if (!run) begin
               run = 1'b1;
               cnt = '0;
            end
         end else begin
            run = 1'b0;
            cnt = '0;
         end
      end else begin
         pending = pending | levels;
         armed   = armed | ~levels;
         if (!run) begin
            run = 1'b1;
            cnt = '0;
         end
         if (b1 || b2) begin
            run = 1'b0;
            cnt = '0;
         end
      end

      state_next.setting_mode     = mode;
      state_next.timer_running    = run;
      state_next.tick_count       = cnt;
      state_next.previous_buttons = levels;
      state_next.armed_flags      = armed;
      state_next.pending_flags    = pending;
      state_next.hours            = hours;
      state_next.minutes          = minutes;
      state_next.seconds          = seconds;

      result.set_mode     = mode;
      result.write_strobe = write;
      result.show_strobe  = show;
      result.hours_out    = hours;
      result.minutes_out  = minutes;
      result.seconds_out  = seconds;
   end

endmodule
`default_nettype wire

/* hw/rtl/clock_set_button_controller_top.sv */
`default_nettype none
// Clock-setting button controller. Each accepted item is one prescaled timer tick
// (two button levels and an optional clock reading) and yields exactly one result
// item with the mode, write/show strobes and the current time copy. The whole step
// is combinational logic from the state registers into the result register, so one
// item is taken every cycle; the result register frees itself in the cycle it is
// taken, so only a stalled, full result register stalls the input. Register 0 is
// hold_ticks, register 1 is quit_ticks; write them only while no item is in flight.
module clock_set_button_controller_top (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire csbc_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output csbc_pkg::rsp_type                      rsp_data,
   input  wire                                    csr_wr_en,
   input  wire [csbc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire [csbc_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   csbc_pkg::state_type state_ff;
   csbc_pkg::state_type state_in;
   csbc_pkg::state_type state_step;
   csbc_pkg::cfg_type   cfg_ff;
   csbc_pkg::cfg_type   cfg_in;
   csbc_pkg::rsp_type   rsp_ff;
   csbc_pkg::rsp_type   rsp_in;
   csbc_pkg::rsp_type   rsp_step;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;

   csbc_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (req_data),
      .state_next (state_step),
      .result     (rsp_step)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = accept ? state_step : state_ff;
      rsp_in       = accept ? rsp_step : rsp_ff;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
      cfg_in       = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            csbc_pkg::CSR_HOLD_TICKS: cfg_in.hold_ticks = csr_wdata;
            csbc_pkg::CSR_QUIT_TICKS: cfg_in.quit_ticks = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= '0;
         cfg_ff.hold_ticks   <= csbc_pkg::HOLD_TICKS_RESET;
         cfg_ff.quit_ticks   <= csbc_pkg::QUIT_TICKS_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         cfg_ff              <= cfg_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_tick_needs_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff.tick_count != '0) |-> state_ff.timer_running)
      else $error("tick count nonzero while timer stopped");

   a_display_unarmed: assert property (@(posedge clock) disable iff (reset)
      !state_ff.setting_mode |-> (state_ff.armed_flags == 2'b00))
      else $error("armed flags set in display mode");

   a_write_in_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.write_strobe) |-> (rsp_ff.set_mode && rsp_ff.show_strobe))
      else $error("write strobe outside set mode or without show");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff && (rsp_ff.set_mode == state_ff.setting_mode)))
      else $error("result does not match updated mode");

endmodule
`default_nettype wire

/* test/clock_set_button_controller_top_test.sv */
module clock_set_button_controller_top_test;
   import csbc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PRINT_LIMIT = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HOLD_TICKS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   clock_set_button_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   req_type tick_queue[$];
   rsp_type expected_display[$];
   rsp_type predicted;
   rsp_type want;
   state_type clk_state;
   cfg_type clk_cfg;

   int fail_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int adjust_count = 0;
   int mode_entries = 0;
   int phase_pushed = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;

   // one tick of the button controller, updates clk_state
   task automatic step_clock_model(input req_type t, output rsp_type r);
      logic [1:0] levels;
      logic both;
      logic [TICK_W-1:0] target;
      logic [HOURS_W:0] h;
      logic [MINUTES_W:0] m;
      levels = {t.button_two_down, t.button_one_down};
      both = &levels;
      r = '0;
      if (levels != clk_state.previous_buttons) begin
         clk_state.timer_running = 1'b0;
         clk_state.tick_count = '0;
      end
      clk_state.previous_buttons = levels;

      if (clk_state.timer_running) begin
         target = clk_state.setting_mode ? clk_cfg.quit_ticks : clk_cfg.hold_ticks;
         if (clk_state.tick_count != TICK_MAX)
            clk_state.tick_count = clk_state.tick_count + 1'b1;
         if (clk_state.tick_count >= target) begin
            clk_state.timer_running = 1'b0;
            clk_state.tick_count = '0;
            if (!clk_state.setting_mode && both) begin
               clk_state.setting_mode = 1'b1;
               mode_entries++;
            end else if (clk_state.setting_mode) begin
               clk_state.setting_mode = 1'b0;
            end
         end
      end

      if (t.time_valid) begin
         clk_state.hours = t.hours_in;
         clk_state.minutes = t.minutes_in;
         clk_state.seconds = t.seconds_in;
         r.show_strobe = 1'b1;
      end

      if (clk_state.pending_flags[0] && levels[0] && clk_state.armed_flags[0]) begin
         clk_state.pending_flags[0] = 1'b0;
         clk_state.armed_flags[0] = 1'b0;
         clk_state.seconds = '0;
         h = {1'b0, clk_state.hours} + 1'b1;
         if (h >= HOURS_PER_DAY)
            h = h - HOURS_PER_DAY;
         clk_state.hours = h[HOURS_W-1:0];
         r.write_strobe = 1'b1;
      end
      if (clk_state.pending_flags[1] && levels[1] && clk_state.armed_flags[1]) begin
         clk_state.pending_flags[1] = 1'b0;
         clk_state.armed_flags[1] = 1'b0;
         clk_state.seconds = '0;
         m = {1'b0, clk_state.minutes} + 1'b1;
         if (m >= MINUTES_PER_HOUR)
            m = m - MINUTES_PER_HOUR;
         clk_state.minutes = m[MINUTES_W-1:0];
         r.write_strobe = 1'b1;
      end
      if (r.write_strobe) begin
         r.show_strobe = 1'b1;
         adjust_count++;
      end

      if (!clk_state.setting_mode) begin
         clk_state.armed_flags = '0;
         if (both) begin
            if (!clk_state.timer_running) begin
               clk_state.timer_running = 1'b1;
               clk_state.tick_count = '0;
            end
         end else begin
            clk_state.timer_running = 1'b0;
            clk_state.tick_count = '0;
         end
      end else begin
         if (levels[0]) clk_state.pending_flags[0] = 1'b1;
         else clk_state.armed_flags[0] = 1'b1;
         if (levels[1]) clk_state.pending_flags[1] = 1'b1;
         else clk_state.armed_flags[1] = 1'b1;
         if (!clk_state.timer_running) begin
            clk_state.timer_running = 1'b1;
            clk_state.tick_count = '0;
         end
         if (levels[0] || levels[1]) begin
            clk_state.timer_running = 1'b0;
            clk_state.tick_count = '0;
         end
      end

      r.set_mode = clk_state.setting_mode;
      r.hours_out = clk_state.hours;
      r.minutes_out = clk_state.minutes;
      r.seconds_out = clk_state.seconds;
   endtask

   function automatic int pick_gap(bit quiet);
      int roll;
      if (quiet)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d, result %0d: %s", cycle_count, results_seen, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_clock_model(req_data, predicted);
            expected_display.push_back(predicted);
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               req_data <= tick_queue.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 79) == 0)
                  send_quiet = !send_quiet;
               send_gap = pick_gap(send_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_display.size() == 0) begin
               report_mismatch("result item with nothing expected");
            end else begin
               want = expected_display.pop_front();
               check_field("set_mode", rsp_data.set_mode, want.set_mode);
               check_field("write_strobe", rsp_data.write_strobe, want.write_strobe);
               check_field("show_strobe", rsp_data.show_strobe, want.show_strobe);
               check_field("hours_out", rsp_data.hours_out, want.hours_out);
               check_field("minutes_out", rsp_data.minutes_out, want.minutes_out);
               check_field("seconds_out", rsp_data.seconds_out, want.seconds_out);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 59) == 0)
               recv_quiet = !recv_quiet;
            stall_left = pick_gap(recv_quiet);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_display.size());
         $display("clock_set_button_controller_top regression: fail");
         $finish;
      end
   end

   function automatic req_type make_tick(bit b1, bit b2);
      req_type t;
      t.button_one_down = b1;
      t.button_two_down = b2;
      t.time_valid = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
         t.hours_in = $urandom_range(0, 31);
         t.minutes_in = $urandom_range(0, 63);
         t.seconds_in = $urandom_range(0, 63);
      end else begin
         t.hours_in = $urandom_range(0, 23);
         t.minutes_in = $urandom_range(0, 59);
         t.seconds_in = $urandom_range(0, 59);
      end
      return t;
   endfunction

   task automatic push_ticks(input bit b1, input bit b2, input int count);
      repeat (count) tick_queue.push_back(make_tick(b1, b2));
      phase_pushed += count;
   endtask

   task automatic push_reading(input bit b1, input bit b2, input bit tv,
                               input int hh, input int mm, input int ss);
      req_type t;
      t = make_tick(b1, b2);
      t.time_valid = tv;
      if (tv) begin
         t.hours_in = hh;
         t.minutes_in = mm;
         t.seconds_in = ss;
      end
      tick_queue.push_back(t);
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_HOLD_TICKS)
         clk_cfg.hold_ticks = value;
      else
         clk_cfg.quit_ticks = value;
   endtask

   task automatic drain;
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_display.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // try to enter set mode, adjust a few times, then often leave again (thresholds above 64 are never reached)
   task automatic set_session;
      int presses;
      int pick;
      int idle;
      if (clk_cfg.hold_ticks > 64)
         push_ticks(1, 1, $urandom_range(1, 60));
      else
         push_ticks(1, 1, clk_cfg.hold_ticks + $urandom_range(1, 3));
      push_ticks(0, 0, $urandom_range(1, 2));
      presses = $urandom_range(1, 8);
      repeat (presses) begin
         pick = $urandom_range(0, 2);
         push_ticks(pick != 1, pick != 0, $urandom_range(1, 3));
         push_ticks(0, 0, $urandom_range(1, 3));
      end
      if ($urandom_range(0, 4) == 0)
         idle = $urandom_range(0, 2);
      else if (clk_cfg.quit_ticks > 64)
         idle = $urandom_range(1, 60);
      else
         idle = clk_cfg.quit_ticks + $urandom_range(0, 2);
      push_ticks(0, 0, idle);
   endtask

   task automatic random_phase(input logic [CSR_DATA_W-1:0] hold, input logic [CSR_DATA_W-1:0] quit,
                               input int count);
      bit paused;
      paused = 1'b0;
      set_register(CSR_HOLD_TICKS, hold);
      set_register(CSR_QUIT_TICKS, quit);
      phase_pushed = 0;
      while (phase_pushed < count) begin
         if (!paused && phase_pushed >= count / 2) begin
            drain;
            paused = 1'b1;
         end
         if ($urandom_range(0, 3) != 0) begin
            set_session;
         end else begin
            repeat ($urandom_range(1, 10))
               push_ticks($urandom_range(0, 1), $urandom_range(0, 1), 1);
         end
      end
      drain;
   endtask

   initial begin
      clk_state = '0;
      clk_cfg.hold_ticks = HOLD_TICKS_RESET;
      clk_cfg.quit_ticks = QUIT_TICKS_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: presses in display mode never adjust
      push_reading(0, 0, 1, 23, 59, 59);
      push_reading(0, 0, 1, 31, 63, 63);
      push_reading(1, 1, 0, 0, 0, 0);
      push_reading(1, 0, 1, 0, 0, 0);
      push_reading(0, 1, 0, 0, 0, 0);
      push_reading(0, 0, 0, 0, 0, 0);
      drain;

      set_register(CSR_HOLD_TICKS, 1);
      set_register(CSR_QUIT_TICKS, 2);
      push_reading(1, 1, 0, 0, 0, 0);
      push_reading(1, 1, 0, 0, 0, 0);
      push_reading(0, 0, 1, 23, 59, 30);
      push_reading(1, 0, 0, 0, 0, 0);    // hour wraps to zero
      push_reading(0, 0, 0, 0, 0, 0);
      push_reading(0, 1, 0, 0, 0, 0);    // minute wraps to zero
      push_reading(0, 0, 1, 31, 63, 5);
      push_reading(1, 1, 0, 0, 0, 0);    // both adjust, out of range values
      push_reading(0, 0, 0, 0, 0, 0);
      push_reading(1, 1, 0, 0, 0, 0);
      push_reading(1, 1, 1, 12, 30, 45);
      push_reading(0, 0, 0, 0, 0, 0);
      push_reading(0, 0, 0, 0, 0, 0);
      push_reading(0, 0, 0, 0, 0, 0);    // quit timer expires
      push_reading(1, 1, 1, 0, 0, 0);
      push_reading(0, 0, 0, 0, 0, 0);
      drain;

      random_phase(1, 1, 260);
      random_phase(0, 0, 260);
      random_phase(3, 7, 260);
      random_phase($urandom_range(2, 12), $urandom_range(2, 30), 260);
      random_phase(16'hFFFF, 1, 200);
      random_phase(1, 16'hFFFF, 260);

      $display("%0d ticks sent, %0d results checked, %0d set mode entries, %0d time adjustments",
               items_sent, results_seen, mode_entries, adjust_count);
      $display("tick thresholds ranged from zero to 65535 including the reset values");
      if (fail_count == 0 && expected_display.size() == 0) begin
         $display("clock_set_button_controller_top regression: pass");
      end else begin
         $display("clock_set_button_controller_top regression: fail");
      end
      $finish;
   end

endmodule
